// ----- hdl/srir_pkg.sv -----
// Shared types, constants and the coil phase table of the stepper ring indexer.
`timescale 1ns / 1ps

package srir_pkg;

	localparam int POS_W   = 8;
	localparam int DELAY_W = 8;
	localparam int PHASE_W = 2;
	localparam int COIL_W  = 6;
	localparam int LEFT_W  = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [DELAY_W-1:0] SLOW_DELAY_RST = 8'd20;
	localparam logic [DELAY_W-1:0] FAST_DELAY_RST = 8'd10;
	localparam logic [LEFT_W-1:0]  LEFT_MAX       = 7'd127;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOW_DELAY = 1'b0,
		REG_FAST_DELAY = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [DELAY_W-1:0] slow_delay;
		logic [DELAY_W-1:0] fast_delay;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [PHASE_W-1:0] phase;
		logic [DELAY_W-1:0] delay;
	} motor_state_t;

	typedef struct packed {
		logic [COIL_W-1:0]  coil_pattern;
		logic [DELAY_W-1:0] step_delay;
		logic [POS_W-1:0]   position;
		logic               moved;
		logic               clockwise;
		logic [LEFT_W-1:0]  distance_left;
	} result_t;

	// Dual-excitation sequence, pins E1 L1 L2 E2 L3 L4 from MSB
	function automatic logic [COIL_W-1:0] coil_of_phase(input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] pat;
		case (ph)
			2'd0: pat = 6'h36;
			2'd1: pat = 6'h2E;
			2'd2: pat = 6'h2D;
			2'd3: pat = 6'h35;
			default: pat = 6'h36;
		endcase
		return pat;
	endfunction

endpackage

// ----- hdl/srir_step_if.sv -----
// Step tick channel: one target position per beat.
`timescale 1ns / 1ps

interface srir_step_if;
	logic                        valid;
	logic                        ready;
	logic [srir_pkg::POS_W-1:0]  target;

	modport source (output valid, output target, input ready);
	modport sink   (input valid, input target, output ready);
endinterface

// ----- hdl/srir_result_if.sv -----
// Result channel: coil pattern, delay and position after each step tick.
`timescale 1ns / 1ps

interface srir_result_if;
	logic                          valid;
	logic                          ready;
	logic [srir_pkg::COIL_W-1:0]   coil_pattern;
	logic [srir_pkg::DELAY_W-1:0]  step_delay;
	logic [srir_pkg::POS_W-1:0]    position;
	logic                          moved;
	logic                          clockwise;
	logic [srir_pkg::LEFT_W-1:0]   distance_left;

	modport source (output valid, output coil_pattern, output step_delay, output position,
		output moved, output clockwise, output distance_left, input ready);
	modport sink   (input valid, input coil_pattern, input step_delay, input position,
		input moved, input clockwise, input distance_left, output ready);
endinterface

// ----- hdl/srir_cfg_if.sv -----
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface srir_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [srir_pkg::CFG_IDX_W-1:0]  index;
	logic [srir_pkg::DELAY_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/stepper_ring_indexer_with_ramp_top.sv -----
// Top level of the stepper ring indexer with acceleration ramp.
`timescale 1ns / 1ps
//
// Each beat on the step channel is one step tick carrying a target position.
// The motor takes one step the short way round the ring toward it (or none
// when already there or when the target is off the ring), advances the coil
// phase, and ramps the inter-step delay between fast_delay and slow_delay.
// Every step beat yields exactly one beat on the result channel.
// The cfg channel writes slow_delay (index 0) and fast_delay (index 1); it is
// always ready. The user must write it only while the block is idle; the
// block does not enforce this. A result passes the input register, then the
// result register once its step beat is accepted; the state update between
// them is combinational. One beat per cycle while the receiver keeps up.
// When the result receiver stalls, the result register holds and the input
// register fills; step.ready then drops until the receiver takes a beat.
// Reset: position 0, coil phase 0, delay 20, slow_delay 20, fast_delay 10,
// both channels empty.

module stepper_ring_indexer_with_ramp_top #(
	parameter int STEPS_PER_REV = 200
) (
	input  logic           clk,
	input  logic           arst_n,
	srir_step_if.sink      step,
	srir_result_if.source  result,
	srir_cfg_if.sink       cfg
);

	srir_pkg::cfg_t regs;

	srir_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	srir_core #(
		.STEPS_PER_REV(STEPS_PER_REV)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.step   (step),
		.result (result)
	);

endmodule

// ----- hdl/srir_cfg.sv -----
// Speed ramp limit registers written through the configuration channel.
`timescale 1ns / 1ps

module srir_cfg (
	input  logic             clk,
	input  logic             arst_n,
	srir_cfg_if.sink         cfg,
	output srir_pkg::cfg_t   regs
);

	srir_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.slow_delay <= srir_pkg::SLOW_DELAY_RST;
			regs_q.fast_delay <= srir_pkg::FAST_DELAY_RST;
		end else if (cfg.valid) begin
			case (srir_pkg::cfg_reg_t'(cfg.index))
				srir_pkg::REG_SLOW_DELAY: regs_q.slow_delay <= cfg.data;
				srir_pkg::REG_FAST_DELAY: regs_q.fast_delay <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/srir_calc.sv -----
// Next-state logic: direction choice, ring step, phase advance and delay ramp.
`timescale 1ns / 1ps

module srir_calc #(
	parameter int STEPS_PER_REV = 200
) (
	input  logic [srir_pkg::POS_W-1:0]  target,
	input  srir_pkg::motor_state_t      cur,
	input  srir_pkg::cfg_t              regs,
	output srir_pkg::motor_state_t      nxt,
	output srir_pkg::result_t           res
);

	localparam logic [8:0] SPR  = 9'(STEPS_PER_REV);
	localparam logic [8:0] HALF = 9'(STEPS_PER_REV / 2);
	localparam logic [7:0] LAST = 8'(STEPS_PER_REV - 1);

	logic [8:0] tgt9, pos9, diff, abs_d, pos_inc, diff2, dist_raw, ring_dist;
	logic       in_range, moving, dir;
	logic [7:0] pos_step;
	logic [1:0] phase_step;
	logic [7:0] delay_step;
	logic signed [9:0] buffer, dist_s;
	srir_pkg::motor_state_t stepped;

	always_comb begin
		tgt9     = {1'b0, target};
		pos9     = {1'b0, cur.pos};
		in_range = tgt9 < SPR;
		moving   = in_range && (target != cur.pos);

		diff  = tgt9 - pos9;
		abs_d = diff[8] ? (9'd0 - diff) : diff;
		// go the other way round when the direct path is over half a turn
		dir   = (!diff[8]) ^ (abs_d > HALF);

		pos_inc = pos9 + 9'd1;
		if (dir) begin
			pos_step   = (pos_inc >= SPR) ? 8'd0 : pos_inc[7:0];
			phase_step = cur.phase + 2'd1;
		end else begin
			pos_step   = (cur.pos == 8'd0) ? LAST : (cur.pos - 8'd1);
			phase_step = cur.phase - 2'd1;
		end

		diff2     = tgt9 - {1'b0, pos_step};
		dist_raw  = diff2[8] ? (9'd0 - diff2) : diff2;
		ring_dist = (dist_raw > HALF) ? (SPR - dist_raw) : dist_raw;

		buffer = $signed({2'b00, regs.slow_delay}) - $signed({2'b00, regs.fast_delay});
		dist_s = $signed({1'b0, ring_dist});

		if ((cur.delay > regs.fast_delay) && (dist_s > buffer)) begin
			delay_step = cur.delay - 8'd1;
		end else if ((cur.delay < regs.slow_delay) && (dist_s < buffer)) begin
			delay_step = cur.delay + 8'd1;
		end else begin
			delay_step = cur.delay;
		end

		stepped.pos   = pos_step;
		stepped.phase = phase_step;
		stepped.delay = delay_step;
		nxt = moving ? stepped : cur;

		res.coil_pattern  = srir_pkg::coil_of_phase(nxt.phase);
		res.step_delay    = nxt.delay;
		res.position      = nxt.pos;
		res.moved         = moving;
		res.clockwise     = moving && dir;
		if (!moving) begin
			res.distance_left = '0;
		end else if (ring_dist > 9'd127) begin
			res.distance_left = srir_pkg::LEFT_MAX;
		end else begin
			res.distance_left = ring_dist[6:0];
		end
	end

endmodule

// ----- hdl/srir_core.sv -----
// Input register, motor state, result register and the handshake between them.
`timescale 1ns / 1ps

module srir_core #(
	parameter int STEPS_PER_REV = 200
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srir_pkg::cfg_t    regs,
	srir_step_if.sink         step,
	srir_result_if.source     result
);

	logic                       valid_s1;
	logic [srir_pkg::POS_W-1:0] target_s1;
	logic                       valid_s2;
	srir_pkg::result_t          res_s2;
	srir_pkg::motor_state_t     state_q;
	srir_pkg::motor_state_t     state_nxt;
	srir_pkg::result_t          res_nxt;
	logic                       advance;

	// advance s1 into the result register when it is empty or being drained
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign step.ready = !valid_s1 || advance;

	srir_calc #(
		.STEPS_PER_REV(STEPS_PER_REV)
	) u_calc (
		.target (target_s1),
		.cur    (state_q),
		.regs   (regs),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			state_q.pos   <= '0;
			state_q.phase <= '0;
			state_q.delay <= srir_pkg::SLOW_DELAY_RST;
		end else begin
			if (step.ready) begin
				valid_s1 <= step.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid && step.ready) begin
			target_s1 <= step.target;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid         = valid_s2;
	assign result.coil_pattern  = res_s2.coil_pattern;
	assign result.step_delay    = res_s2.step_delay;
	assign result.position      = res_s2.position;
	assign result.moved         = res_s2.moved;
	assign result.clockwise     = res_s2.clockwise;
	assign result.distance_left = res_s2.distance_left;

	a_hold_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !res_nxt.moved |=> $stable(state_q))
		else $error("motor state changed without a step");

	a_phase_cw: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nxt.clockwise |=> state_q.phase == $past(state_q.phase) + 2'd1)
		else $error("clockwise step did not advance the coil phase");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 && res_s2.position == state_q.pos)
		else $error("result register does not match the motor state");

	a_pos_on_ring: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> {1'b0, res_s2.position} < 9'(STEPS_PER_REV))
		else $error("reported position is off the ring");

endmodule

// ----- dv/tb_stepper_ring_indexer_with_ramp_top.sv -----
// Testbench for the stepper ring indexer: random step ticks checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_stepper_ring_indexer_with_ramp_top;

	localparam int RING_STEPS = 200;
	localparam int PHASE_TICKS = 250;
	localparam logic [srir_pkg::COIL_W-1:0] COIL_SEQ [4] = '{6'h36, 6'h2E, 6'h2D, 6'h35};

	// Tracks the motor state and holds the results still owed by the block.
	class motor_track;
		logic [srir_pkg::POS_W-1:0]   pos;
		logic [srir_pkg::PHASE_W-1:0] phase;
		logic [srir_pkg::DELAY_W-1:0] delay;
		logic [srir_pkg::DELAY_W-1:0] slow;
		logic [srir_pkg::DELAY_W-1:0] fast;
		srir_pkg::result_t            pending_results[$];
		int                           errs;

		function new();
			pos   = '0;
			phase = '0;
			delay = srir_pkg::SLOW_DELAY_RST;
			slow  = srir_pkg::SLOW_DELAY_RST;
			fast  = srir_pkg::FAST_DELAY_RST;
			errs  = 0;
		endfunction

		function void set_reg(srir_pkg::cfg_reg_t idx, logic [srir_pkg::DELAY_W-1:0] val);
			case (idx)
				srir_pkg::REG_SLOW_DELAY: slow = val;
				srir_pkg::REG_FAST_DELAY: fast = val;
				default: ;
			endcase
		endfunction

		function int ring_gap(int a, int b);
			int d;
			d = (a > b) ? a - b : b - a;
			if (d > RING_STEPS / 2) d = RING_STEPS - d;
			return d;
		endfunction

		// Advance the motor by one step tick and queue the result it owes.
		function void note_tick(logic [srir_pkg::POS_W-1:0] tgt);
			srir_pkg::result_t exp;
			int      d;
			int      gap;
			int      buffer;
			bit      cw;
			exp.moved         = 1'b0;
			exp.clockwise     = 1'b0;
			exp.distance_left = '0;
			if (int'(tgt) < RING_STEPS && tgt != pos) begin
				d  = int'(tgt) - int'(pos);
				cw = 1'b1;
				if (d < 0) begin
					d  = -d;
					cw = 1'b0;
				end
				// the direct path is over half a turn: go the other way
				if (d > RING_STEPS / 2) cw = !cw;
				if (cw) begin
					phase = phase + 1'b1;
					pos   = (int'(pos) + 1 >= RING_STEPS) ? '0 : pos + 1'b1;
				end else begin
					phase = phase - 1'b1;
					pos   = (pos == 0) ? srir_pkg::POS_W'(RING_STEPS - 1) : pos - 1'b1;
				end
				gap    = ring_gap(int'(tgt), int'(pos));
				buffer = int'(slow) - int'(fast);
				if (delay > fast && gap > buffer) delay = delay - 1'b1;
				else if (delay < slow && gap < buffer) delay = delay + 1'b1;
				exp.moved         = 1'b1;
				exp.clockwise     = cw;
				exp.distance_left = (gap > int'(srir_pkg::LEFT_MAX)) ? srir_pkg::LEFT_MAX :
					srir_pkg::LEFT_W'(gap);
			end
			exp.coil_pattern = COIL_SEQ[phase];
			exp.step_delay   = delay;
			exp.position     = pos;
			pending_results.push_back(exp);
		endfunction

		function void match_result(srir_pkg::result_t got);
			srir_pkg::result_t exp;
			if (pending_results.size() == 0) begin
				errs++;
				if (errs <= 10)
					$display("unexpected result beat: coil=%h delay=%0d pos=%0d moved=%b cw=%b left=%0d",
						got.coil_pattern, got.step_delay, got.position, got.moved,
						got.clockwise, got.distance_left);
				return;
			end
			exp = pending_results.pop_front();
			if (got.coil_pattern !== exp.coil_pattern || got.step_delay !== exp.step_delay ||
				got.position !== exp.position || got.moved !== exp.moved ||
				got.clockwise !== exp.clockwise || got.distance_left !== exp.distance_left) begin
				errs++;
				if (errs <= 10) begin
					$display("mismatch exp: coil=%h delay=%0d pos=%0d moved=%b cw=%b left=%0d",
						exp.coil_pattern, exp.step_delay, exp.position, exp.moved,
						exp.clockwise, exp.distance_left);
					$display("         got: coil=%h delay=%0d pos=%0d moved=%b cw=%b left=%0d",
						got.coil_pattern, got.step_delay, got.position, got.moved,
						got.clockwise, got.distance_left);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	int   sent;

	motor_track track;

	srir_step_if   step_ch();
	srir_result_if result_ch();
	srir_cfg_if    cfg_ch();

	stepper_ring_indexer_with_ramp_top #(
		.STEPS_PER_REV(RING_STEPS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Check each accepted result beat, then pick the next ready level.
	always @(posedge clk) begin
		srir_pkg::result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.coil_pattern  = result_ch.coil_pattern;
			got.step_delay    = result_ch.step_delay;
			got.position      = result_ch.position;
			got.moved         = result_ch.moved;
			got.clockwise     = result_ch.clockwise;
			got.distance_left = result_ch.distance_left;
			track.match_result(got);
		end
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_tick(input logic [srir_pkg::POS_W-1:0] tgt);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			step_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		step_ch.valid  <= 1'b1;
		step_ch.target <= tgt;
		do @(posedge clk); while (!step_ch.ready);
		track.note_tick(tgt);
		sent++;
	endtask

	task automatic drain();
		step_ch.valid <= 1'b0;
		while (track.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input srir_pkg::cfg_reg_t idx,
		input logic [srir_pkg::DELAY_W-1:0] val);
		drain();
		repeat (2) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		track.set_reg(idx, val);
	endtask

	// Hold one target until the motor gets there, sometimes cut short.
	task automatic run_move();
		int span;
		int hops;
		int dest;
		span = ($urandom_range(9) < 7) ? $urandom_range(1, 30) : $urandom_range(1, 100);
		dest = $urandom_range(1) ? int'(track.pos) + span : int'(track.pos) - span;
		dest = (dest + RING_STEPS) % RING_STEPS;
		hops = ($urandom_range(9) == 0) ? $urandom_range(1, span) : span + $urandom_range(0, 3);
		repeat (hops) send_tick(srir_pkg::POS_W'(dest));
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 3)) send_tick(srir_pkg::POS_W'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [srir_pkg::POS_W-1:0]   opening [16];
		logic [srir_pkg::DELAY_W-1:0] slow_set [8];
		logic [srir_pkg::DELAY_W-1:0] fast_set [8];
		int                           quota;
		// at target, off the ring, one step each way, both wraps, exactly half a
		// turn, just over half a turn, then bit patterns and a few held ticks
		opening  = '{8'd0, 8'd255, 8'd200, 8'd1, 8'd0, 8'd199, 8'd0, 8'd100,
			8'd101, 8'd103, 8'd128, 8'd64, 8'd170, 8'd85, 8'd85, 8'd85};
		slow_set = '{8'd20, 8'd255, 8'd1, 8'd255, 8'd5, 8'd1, 8'd40, 8'd0};
		fast_set = '{8'd10, 8'd1, 8'd1, 8'd255, 8'd40, 8'd255, 8'd12, 8'd0};
		track = new();
		sent      = 0;
		idle_pct  = 0;
		stall_pct = 0;
		arst_n           <= 1'b0;
		step_ch.valid    <= 1'b0;
		step_ch.target   <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= srir_pkg::REG_SLOW_DELAY;
		cfg_ch.data      <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) send_tick(opening[i]);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7) begin
				slow_set[ph] = srir_pkg::DELAY_W'($urandom_range(1, 255));
				fast_set[ph] = srir_pkg::DELAY_W'($urandom_range(1, 255));
			end
			write_reg(srir_pkg::REG_SLOW_DELAY, slow_set[ph]);
			write_reg(srir_pkg::REG_FAST_DELAY, fast_set[ph]);
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 64; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 64; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			quota = sent + PHASE_TICKS;
			while (sent < quota) begin
				if ($urandom_range(99) < 85) run_move();
				else run_noise();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (track.errs == 0 && track.pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/srir_pkg.sv
hdl/srir_step_if.sv
hdl/srir_result_if.sv
hdl/srir_cfg_if.sv
hdl/srir_cfg.sv
hdl/srir_calc.sv
hdl/srir_core.sv
hdl/stepper_ring_indexer_with_ramp_top.sv
dv/tb_stepper_ring_indexer_with_ramp_top.sv
